### rtl/qea_pkg.sv
`timescale 1ns / 1ps

package qea_pkg;

  // Hold-off window for detent acceleration and switch qualification
  localparam logic [31:0] HOLD_MS = 32'd100;

  // Score of an (old, new) pin state pair, indexed by {old_a, old_b, new_a, new_b}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0,
    2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  // Pin state after reset: both pins high
  localparam logic [1:0] PIN_RESET = 2'b11;

  // Detent threshold of the step accumulator
  localparam logic signed [3:0] STEP_DETENT = 4'sd4;

  // Largest acceleration factor
  localparam logic [15:0] FACTOR_MAX = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_COUNT   = 3'd0,
    CFG_MAX_COUNT   = 3'd1,
    CFG_ROLLOVER    = 3'd2,
    CFG_ACCEL_STEP  = 3'd3,
    CFG_ACCEL_START = 3'd4,
    CFG_ACCEL_LIMIT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] min_count;
    logic signed [31:0] max_count;
    logic               rollover;
    logic [7:0]         accel_step;
    logic [7:0]         accel_start;
    logic [15:0]        accel_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_count:   32'sd0,
    max_count:   32'sd100,
    rollover:    1'b0,
    accel_step:  8'd1,
    accel_start: 8'd1,
    accel_limit: 16'd16
  };

  // Classified event passed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_UP     = 2'd1,
    CMD_DOWN   = 2'd2,
    CMD_SWITCH = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        sw;
    logic [31:0] now_ms;
  } cmd_t;

endpackage

### rtl/qea_if.sv
`timescale 1ns / 1ps

// Event channel
interface qea_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        pin_a;
  logic        pin_b;
  logic        switch_level;
  logic [31:0] now_ms;

  modport source (output valid, action, pin_a, pin_b, switch_level, now_ms, input ready);
  modport sink   (input valid, action, pin_a, pin_b, switch_level, now_ms, output ready);
endinterface

// Result channel
interface qea_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] count;
  logic               moved;
  logic               pressed;
  logic               released;

  modport source (output valid, count, moved, pressed, released, input ready);
  modport sink   (input valid, count, moved, pressed, released, output ready);
endinterface

// Register write channel
interface qea_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/qea_front.sv
`timescale 1ns / 1ps

module qea_front import qea_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  qea_in_if.sink      in_ch,
  output logic        push_valid,
  input  logic        push_ready,
  output cmd_t        push_data
);

  logic [1:0]        pin_state_r, pin_state_nxt;
  logic signed [3:0] step_sum_r, step_sum_nxt;
  logic              fire;
  logic              detent;
  logic signed [1:0] score;
  logic signed [3:0] sum;

  assign fire       = in_ch.valid && push_ready;
  assign in_ch.ready = push_ready;
  assign push_valid = in_ch.valid;

  // Score the pin transition and classify the event
  always_comb begin
    score        = STEP_TABLE[{pin_state_r, in_ch.pin_a, in_ch.pin_b}];
    sum          = step_sum_r + $signed({{2{score[1]}}, score});
    detent       = (sum == STEP_DETENT) || (sum == -STEP_DETENT);
    pin_state_nxt = pin_state_r;
    step_sum_nxt  = step_sum_r;
    push_data.sw     = in_ch.switch_level;
    push_data.now_ms = in_ch.now_ms;
    if (in_ch.action) begin
      push_data.kind = CMD_SWITCH;
    end else begin
      pin_state_nxt = {in_ch.pin_a, in_ch.pin_b};
      if (detent) begin
        step_sum_nxt   = 4'sd0;
        push_data.kind = (sum > 4'sd0) ? CMD_UP : CMD_DOWN;
      end else begin
        step_sum_nxt   = sum;
        push_data.kind = CMD_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_state_r <= PIN_RESET;
      step_sum_r  <= 4'sd0;
    end else if (fire) begin
      pin_state_r <= pin_state_nxt;
      step_sum_r  <= step_sum_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Accumulator stays within one detent of zero
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step_sum_r < STEP_DETENT) && (step_sum_r > -STEP_DETENT))
    else $error("step accumulator out of range");

  // A detent event clears the accumulator
  a_detent_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (push_data.kind == CMD_UP || push_data.kind == CMD_DOWN) |=> step_sum_r == 4'sd0)
    else $error("accumulator not cleared after detent");
`endif

endmodule

### rtl/qea_fifo.sv
`timescale 1ns / 1ps

module qea_fifo import qea_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  // Fill level never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue overfilled");
`endif

endmodule

### rtl/qea_back.sv
`timescale 1ns / 1ps

module qea_back import qea_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  qea_out_if.source   out_ch
);

  // Stage A: acceleration and switch hold-off
  logic        a_valid_r;
  cmd_kind_t   a_kind_r;
  logic        a_pressed_r, a_released_r;
  logic [15:0] a_amount_r;
  logic [15:0] detent_gain_r, detent_gain_nxt;
  logic [15:0] accel_factor_r, accel_factor_nxt;
  logic [31:0] last_detent_r, last_release_r;
  logic        a_fire, a_ready;
  logic [31:0] detent_gap, release_gap;
  logic [16:0] factor_sum;
  logic [15:0] factor_sat;
  logic [31:0] product;
  logic        sw_ok;

  // Stage B: position update and result register
  logic               out_valid_r;
  logic               out_moved_r, out_pressed_r, out_released_r;
  logic signed [31:0] position_r, position_nxt;
  logic               b_fire, b_ready;
  logic signed [32:0] pos_ext, amt_ext, sum_up, sum_dn, max_ext, min_ext;

  assign b_ready   = !out_valid_r || out_ch.ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign cmd_ready = a_ready;
  assign a_fire    = cmd_valid && a_ready;
  assign b_fire    = a_valid_r && b_ready;

  // Acceleration: grow the factor on a fast detent, restart on a slow one
  always_comb begin
    detent_gap  = cmd.now_ms - last_detent_r;
    release_gap = cmd.now_ms - last_release_r;
    sw_ok       = release_gap > HOLD_MS;
    factor_sum  = {1'b0, accel_factor_r} + {9'b0, cfg.accel_step};
    factor_sat  = factor_sum[16] ? FACTOR_MAX : factor_sum[15:0];
    product     = detent_gain_r * factor_sat;
    if (detent_gap < HOLD_MS) begin
      accel_factor_nxt = factor_sat;
      detent_gain_nxt  = (product > {16'b0, cfg.accel_limit}) ? cfg.accel_limit
                                                              : product[15:0];
    end else begin
      accel_factor_nxt = {8'b0, cfg.accel_start};
      detent_gain_nxt  = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r      <= 1'b0;
      detent_gain_r  <= 16'd1;
      accel_factor_r <= {8'b0, CFG_RESET.accel_start};
      last_detent_r  <= '0;
      last_release_r <= '0;
    end else begin
      if (a_fire) begin
        a_valid_r <= 1'b1;
      end else if (b_fire) begin
        a_valid_r <= 1'b0;
      end
      if (a_fire) begin
        case (cmd.kind)
          CMD_UP, CMD_DOWN: begin
            detent_gain_r  <= detent_gain_nxt;
            accel_factor_r <= accel_factor_nxt;
            last_detent_r  <= cmd.now_ms;
          end
          CMD_SWITCH: begin
            if (sw_ok && cmd.sw) begin
              last_release_r <= cmd.now_ms;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Stage A payload
  always_ff @(posedge clk) begin
    if (a_fire) begin
      a_kind_r     <= cmd.kind;
      a_amount_r   <= detent_gain_nxt;
      a_pressed_r  <= (cmd.kind == CMD_SWITCH) && sw_ok && !cmd.sw;
      a_released_r <= (cmd.kind == CMD_SWITCH) && sw_ok && cmd.sw;
    end
  end

  // Position move with clamp or rollover at the limits
  always_comb begin
    pos_ext = {position_r[31], position_r};
    amt_ext = $signed({17'b0, a_amount_r});
    max_ext = {cfg.max_count[31], cfg.max_count};
    min_ext = {cfg.min_count[31], cfg.min_count};
    sum_up  = pos_ext + amt_ext;
    sum_dn  = pos_ext - amt_ext;
    case (a_kind_r)
      CMD_UP: begin
        if (sum_up > max_ext) begin
          position_nxt = cfg.rollover ? cfg.min_count : cfg.max_count;
        end else begin
          position_nxt = sum_up[31:0];
        end
      end
      CMD_DOWN: begin
        if (sum_dn < min_ext) begin
          position_nxt = cfg.rollover ? cfg.max_count : cfg.min_count;
        end else begin
          position_nxt = sum_dn[31:0];
        end
      end
      default: begin
        position_nxt = position_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      position_r  <= '0;
    end else begin
      if (b_fire) begin
        out_valid_r <= 1'b1;
        position_r  <= position_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result flags
  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_moved_r    <= (a_kind_r == CMD_UP) || (a_kind_r == CMD_DOWN);
      out_pressed_r  <= a_pressed_r;
      out_released_r <= a_released_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.count    = position_r;
  assign out_ch.moved    = out_moved_r;
  assign out_ch.pressed  = out_pressed_r;
  assign out_ch.released = out_released_r;

`ifndef ASSERT_OFF
  // A result reports at most one kind of event
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_moved_r, out_pressed_r, out_released_r}))
    else $error("result flags more than one event");

  // A stalled stage A keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_ready |=> a_valid_r && $stable(a_amount_r) && $stable(a_kind_r))
    else $error("stage A item lost under stall");

  // A slow detent restarts the acceleration amount at one
  a_slow_restart: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && (cmd.kind == CMD_UP || cmd.kind == CMD_DOWN) && (detent_gap >= HOLD_MS)
    |=> a_amount_r == 16'd1)
    else $error("slow detent did not restart acceleration");
`endif

endmodule

### rtl/quadrature_encoder_accel_counter.sv
`timescale 1ns / 1ps

// Quadrature encoder counter with detent acceleration and push switch.
// in_ch: one event per item. action 0 carries the encoder pin levels, action 1
//   the push switch level; now_ms is the event time in milliseconds.
// out_ch: exactly one result per event: the count after the event and flags
//   for a completed detent, a qualified press or a qualified release.
// cfg_ch: register writes (index, data), always ready; write only while idle.
//   Unknown indexes are ignored. Limit writes do not re-clamp the count.
// Path: the front classification is written into the queue (QUEUE_DEPTH
//   entries, two by default) at the accepting edge, then passes the
//   acceleration stage and the position stage with the result register.
// Throughput: one event per clock while out_ch.ready stays high; the acceleration
//   stage closes its amount/factor loop with one 16x16 multiply.
// Reset (rst_n low, synchronous): count 0, pins taken as both high, step
//   accumulator 0, acceleration amount and factor 1, timestamps 0, and the
//   registers return to their reset values.
// When the receiver stalls, the result holds and up to QUEUE_DEPTH + 1 more events
//   (three by default) are absorbed by the acceleration stage and the queue before in_ch.ready drops.
module quadrature_encoder_accel_counter import qea_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  qea_in_if.sink      in_ch,
  qea_out_if.source   out_ch,
  qea_cfg_if.sink     cfg_ch
);

  cfg_t cfg_r;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MIN_COUNT:   cfg_r.min_count   <= $signed(cfg_ch.data);
        CFG_MAX_COUNT:   cfg_r.max_count   <= $signed(cfg_ch.data);
        CFG_ROLLOVER:    cfg_r.rollover    <= cfg_ch.data[0];
        CFG_ACCEL_STEP:  cfg_r.accel_step  <= cfg_ch.data[7:0];
        CFG_ACCEL_START: cfg_r.accel_start <= cfg_ch.data[7:0];
        CFG_ACCEL_LIMIT: cfg_r.accel_limit <= cfg_ch.data[15:0];
        default: begin
        end
      endcase
    end
  end

  qea_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  qea_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  qea_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_data),
    .out_ch    (out_ch)
  );

endmodule
